// ===== rtl/rau_pkg.sv =====
package rau_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;

    localparam mode_t MODE_ADD = 2'd0;
    localparam mode_t MODE_SUB = 2'd1;
    localparam mode_t MODE_MUL = 2'd2;
    localparam mode_t MODE_DIV = 2'd3;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_DIVZERO  = 2'd1;
    localparam status_t ST_OVERFLOW = 2'd2;
    localparam status_t ST_BADDEN   = 2'd3;

    // One request: two fractions and the operation.
    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } req_t;

    // One result: reduced fraction and status.
    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        status_t            status;
    } rsp_t;

endpackage

// ===== rtl/rational_arith_unit.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  rau_pkg::req_t (mode, a_num, a_den, b_num, b_den)
// rsp       out        rsp_valid/rsp_stall  rau_pkg::rsp_t (res_num, res_den, status)
//
// For add and subtract, a request first runs a binary GCD of the denominators on
// the shared 66-bit subtractor (one step per cycle) and two restoring divisions;
// multiply and divide start at the multiplier. Then come the multiplier states
// S_MUL1 to S_MUL3, a second binary GCD over the 64-bit numerator magnitude and
// denominator product and two more divisions. Error results skip to S_DONE. Reset
// (rst_n, asynchronous, active low) clears the sequencer and the output valid. The
// block takes no request while one is in work. A finished result waits in the output
// register, so a new request is taken while rsp_stall holds the old one.
module rational_arith_unit #(
    parameter int WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rau_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rau_pkg::rsp_t rsp
);

    // Half of the result range: the numerator must lie in [-HALF, HALF-1] and
    // the denominator must not exceed HALF-1.
    localparam logic [63:0] HALF = 64'd1 << (WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_DONE
    } state_t;

    // What the divider is working on.
    typedef enum logic [1:0] {
        D_QA,
        D_QB,
        D_MAG,
        D_DEN
    } div_op_t;

    state_t             state_reg;
    rau_pkg::req_t      req_reg;
    rau_pkg::rsp_t      res_reg;
    rau_pkg::rsp_t      rsp_reg;
    logic               rsp_valid_reg;

    // Binary GCD registers. k counts common factors of two.
    logic [63:0]        u_reg;
    logic [63:0]        v_reg;
    logic [5:0]         k_reg;
    logic               phase_reg;

    // Restoring divider: remainder, quotient/dividend shifter, divisor, step count.
    logic [63:0]        dr_reg;
    logic [63:0]        dq_reg;
    logic [63:0]        dd_reg;
    logic [5:0]         cnt_reg;
    div_op_t            op_reg;

    // Intermediates.
    logic [32:0]        qa_reg;
    logic [32:0]        qb_reg;
    logic signed [63:0] p1_reg;
    logic signed [63:0] p2_reg;
    logic [63:0]        den_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;

    // Shared subtractor.
    logic [64:0]        sub_x;
    logic [64:0]        sub_y;
    logic [65:0]        diff;
    logic               ge;
    logic [64:0]        shifted;

    // Multiplier.
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic signed [65:0] prod;
    logic               addsub;

    logic signed [32:0] an_x;
    logic signed [32:0] bn_x;
    logic signed [32:0] bn_abs;
    logic signed [32:0] ad_x;
    logic signed [32:0] bd_x;

    logic signed [64:0] num_sum;
    logic               ovf;
    logic               free_out;

    assign an_x   = {req_reg.a_num[31], req_reg.a_num};
    assign bn_x   = {req_reg.b_num[31], req_reg.b_num};
    assign bn_abs = req_reg.b_num[31] ? -bn_x : bn_x;
    assign ad_x   = {2'b00, req_reg.a_den};
    assign bd_x   = {2'b00, req_reg.b_den};
    assign addsub = (req_reg.mode == rau_pkg::MODE_ADD) || (req_reg.mode == rau_pkg::MODE_SUB);

    assign shifted = {dr_reg, dq_reg[63]};

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            sub_x = shifted;
            sub_y = {1'b0, dd_reg};
        end
        else
        begin
            sub_x = {1'b0, u_reg};
            sub_y = {1'b0, v_reg};
        end
    end

    assign diff = {1'b0, sub_x} - {1'b0, sub_y};
    assign ge   = ~diff[65];

    // Operand selection for the multiplier states S_MUL1 to S_MUL3.
    always_comb
    begin
        ma = an_x;
        mb = bd_x;
        case (state_reg)
            S_MUL1:
            begin
                ma = an_x;
                if (addsub)
                    mb = qb_reg;
                else if (req_reg.mode == rau_pkg::MODE_MUL)
                    mb = bn_x;
                else
                    mb = bd_x;
            end
            S_MUL2:
            begin
                ma = bn_x;
                mb = qa_reg;
            end
            S_MUL3:
            begin
                ma = addsub ? qa_reg : ad_x;
                mb = (req_reg.mode == rau_pkg::MODE_DIV) ? bn_abs : bd_x;
            end
            default:
            begin
                ma = an_x;
                mb = bd_x;
            end
        endcase
    end

    assign prod = ma * mb;

    always_comb
    begin
        case (req_reg.mode)
            rau_pkg::MODE_ADD: num_sum = {p1_reg[63], p1_reg} + {p2_reg[63], p2_reg};
            rau_pkg::MODE_SUB: num_sum = {p1_reg[63], p1_reg} - {p2_reg[63], p2_reg};
            rau_pkg::MODE_MUL: num_sum = {p1_reg[63], p1_reg};
            default:           num_sum = req_reg.b_num[31] ? -{p1_reg[63], p1_reg}
                                                           : {p1_reg[63], p1_reg};
        endcase
    end

    // Range check of the reduced result; den_final holds the reduced denominator
    // on the last step of the D_DEN division, mag_reg the reduced magnitude.
    logic [63:0] den_final;
    assign den_final = {dq_reg[62:0], ge};
    assign ovf = (den_final > HALF - 64'd1)
              || (neg_reg ? (mag_reg > HALF) : (mag_reg > HALF - 64'd1));

    assign free_out  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && free_out)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg <= req;
                        if (req.a_den == '0 || req.b_den == '0)
                        begin
                            res_reg   <= '{res_num: '0, res_den: 31'd1,
                                           status: rau_pkg::ST_BADDEN};
                            state_reg <= S_DONE;
                        end
                        else if (req.mode == rau_pkg::MODE_DIV && req.b_num == '0)
                        begin
                            res_reg   <= '{res_num: '0, res_den: 31'd1,
                                           status: rau_pkg::ST_DIVZERO};
                            state_reg <= S_DONE;
                        end
                        else if (req.mode == rau_pkg::MODE_ADD
                              || req.mode == rau_pkg::MODE_SUB)
                        begin
                            u_reg     <= {33'b0, req.a_den};
                            v_reg     <= {33'b0, req.b_den};
                            k_reg     <= '0;
                            phase_reg <= 1'b0;
                            state_reg <= S_GCD;
                        end
                        else
                        begin
                            state_reg <= S_MUL1;
                        end
                    end
                end

                S_GCD:
                begin
                    // v never reaches zero; the loop ends when u does.
                    if (u_reg == '0)
                    begin
                        op_reg    <= phase_reg ? D_MAG : D_QA;
                        state_reg <= S_DIV;
                        cnt_reg   <= '0;
                        dr_reg    <= '0;
                        dd_reg    <= v_reg << k_reg;
                        dq_reg    <= phase_reg ? mag_reg : {33'b0, req_reg.a_den};
                    end
                    else if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + 6'd1;
                    end
                    else if (!u_reg[0])
                        u_reg <= u_reg >> 1;
                    else if (!v_reg[0])
                        v_reg <= v_reg >> 1;
                    else if (ge)
                        u_reg <= diff[63:0];
                    else
                    begin
                        u_reg <= v_reg;
                        v_reg <= u_reg;
                    end
                end

                S_DIV:
                begin
                    dr_reg  <= ge ? diff[63:0] : shifted[63:0];
                    dq_reg  <= {dq_reg[62:0], ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        cnt_reg <= '0;
                        dr_reg  <= '0;
                        unique case (op_reg)
                            D_QA:
                            begin
                                qa_reg <= den_final[32:0];
                                op_reg <= D_QB;
                                dq_reg <= {33'b0, req_reg.b_den};
                            end
                            D_QB:
                            begin
                                qb_reg    <= den_final[32:0];
                                state_reg <= S_MUL1;
                            end
                            D_MAG:
                            begin
                                mag_reg <= den_final;
                                op_reg  <= D_DEN;
                                dq_reg  <= den_reg;
                            end
                            D_DEN:
                            begin
                                if (ovf)
                                    res_reg <= '{res_num: '0, res_den: 31'd1,
                                                 status: rau_pkg::ST_OVERFLOW};
                                else
                                    res_reg <= '{res_num: neg_reg ? 32'd0 - mag_reg[31:0]
                                                                  : mag_reg[31:0],
                                                 res_den: den_final[30:0],
                                                 status: rau_pkg::ST_OK};
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_MUL1:
                begin
                    p1_reg    <= prod[63:0];
                    state_reg <= S_MUL2;
                end

                S_MUL2:
                begin
                    p2_reg    <= prod[63:0];
                    state_reg <= S_MUL3;
                end

                S_MUL3:
                begin
                    den_reg   <= prod[63:0];
                    state_reg <= S_SUM;
                end

                S_SUM:
                begin
                    neg_reg   <= num_sum[64];
                    mag_reg   <= num_sum[64] ? 64'd0 - num_sum[63:0] : num_sum[63:0];
                    u_reg     <= num_sum[64] ? 64'd0 - num_sum[63:0] : num_sum[63:0];
                    v_reg     <= den_reg;
                    k_reg     <= '0;
                    phase_reg <= 1'b1;
                    state_reg <= S_GCD;
                end

                S_DONE:
                begin
                    if (free_out)
                    begin
                        rsp_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // A new result appears only out of the finishing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("result shown without finishing state");

    // Any error status carries the fraction 0/1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != rau_pkg::ST_OK) |-> (rsp.res_num == '0 && rsp.res_den == 31'd1))
        else $error("error result not 0/1");

    // The divider never runs on a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dd_reg != '0))
        else $error("division by zero divisor");

    // The GCD loop keeps its second operand nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD) |-> (v_reg != '0))
        else $error("gcd operand collapsed to zero");

    // A waiting result is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

endmodule
